@@ rtl/lfws_pkg.sv @@
// ============================================================================
// lfws_pkg
// Types, constants and helpers shared by the wheel speed controller modules.
// ============================================================================
package lfws_pkg;

  // Digit-serial multiplier geometry: 32-bit magnitudes, 4-bit digits.
  localparam int MUL_W   = 32;
  localparam int DIGIT_W = 4;
  localparam int STEPS   = MUL_W / DIGIT_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int SUM_W   = MUL_W + DIGIT_W;
  localparam int PROD_W  = 2 * MUL_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEV_WEIGHT    = 3'd0;
  localparam logic [2:0] REG_GROWTH_WEIGHT = 3'd1;
  localparam logic [2:0] REG_SLOPE_WEIGHT  = 3'd2;
  localparam logic [2:0] REG_BETA_LIMIT    = 3'd3;
  localparam logic [2:0] REG_NEAR_GAIN     = 3'd4;
  localparam logic [2:0] REG_FAR_GAIN      = 3'd5;
  localparam logic [2:0] REG_MIN_SPEED     = 3'd6;
  localparam logic [2:0] REG_MAX_SPEED     = 3'd7;

  // Function codes carried with each frame.
  localparam logic [1:0] FUNC_FOLLOW      = 2'd0;
  localparam logic [1:0] FUNC_SPRAY_STOP  = 2'd1;
  localparam logic [1:0] FUNC_SPRAY_REV   = 2'd2;
  localparam logic [1:0] FUNC_SPRAY_FWD   = 2'd3;

  localparam logic signed [7:0] REVERSE_SPEED = -8'sd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXTRA,
    ST_TERM,
    ST_P2,
    ST_P4,
    ST_P5,
    ST_DRIVE,
    ST_SUM,
    ST_CLAMP,
    ST_OUT
  } lfws_state_t;

  // Saturate a 33-bit signed sum to signed 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/lfws_mul.sv @@
// ============================================================================
// lfws_mul
// Digit-serial Q-format multiplier with truncation toward zero and saturation.
// ============================================================================
module lfws_mul
  import lfws_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] res
);

  logic [MUL_W-1:0]  a_mag;
  logic [PROD_W-1:0] prod;
  logic              neg;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic              fin;

  logic [SUM_W-1:0]  step_sum;
  logic [MUL_W-1:0]  q;
  logic              hi_nz;
  logic signed [31:0] sat_res;

  // One digit of the shifted multiplier operand is consumed per cycle.
  assign step_sum = SUM_W'(prod[PROD_W-1:MUL_W])
                  + SUM_W'(a_mag) * SUM_W'(prod[DIGIT_W-1:0]);

  // Shift the magnitude down by FRAC_BITS; magnitude truncation is
  // truncation toward zero of the signed product.
  assign q     = prod[FRAC_BITS +: MUL_W];
  assign hi_nz = |prod[PROD_W-1:FRAC_BITS+MUL_W];

  always_comb begin
    if (neg) begin
      if (hi_nz || (q[MUL_W-1] && (|q[MUL_W-2:0]))) begin
        sat_res = 32'sh8000_0000;
      end else begin
        sat_res = $signed(32'd0 - q);
      end
    end else begin
      if (hi_nz || q[MUL_W-1]) begin
        sat_res = 32'sh7fff_ffff;
      end else begin
        sat_res = $signed(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        fin <= 1'b0;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(STEPS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= a[31] ? (32'd0 - a) : a;
      prod  <= {{MUL_W{1'b0}}, (b[31] ? (32'd0 - b) : b)};
      neg   <= a[31] ^ b[31];
    end else if (run) begin
      prod <= {step_sum, prod[MUL_W-1:DIGIT_W]};
    end
    if (fin) begin
      res <= sat_res;
    end
  end

endmodule

@@ rtl/lfws_spd.sv @@
// ============================================================================
// lfws_spd
// Clamps a fixed-point wheel value to the speed range and truncates it.
// ============================================================================
module lfws_spd
  import lfws_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 34
) (
  input  logic signed [SW-1:0] v,
  input  logic signed [7:0]    min_speed,
  input  logic signed [7:0]    max_speed,
  output logic signed [7:0]    speed
);

  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] vc;
  logic signed [SW-1:0] q;
  logic signed [SW-1:0] qr;
  logic                 round_up;

  assign lo = $signed({{(SW-8){min_speed[7]}}, min_speed}) <<< FRAC_BITS;
  assign hi = $signed({{(SW-8){max_speed[7]}}, max_speed}) <<< FRAC_BITS;

  // The upper bound is applied last, so it wins when the bounds cross.
  always_comb begin
    vc = v;
    if (vc < lo) begin
      vc = lo;
    end
    if (vc > hi) begin
      vc = hi;
    end
  end

  assign q        = vc >>> FRAC_BITS;
  assign round_up = vc[SW-1] & (|vc[FRAC_BITS-1:0]);
  assign qr       = q + $signed({{(SW-1){1'b0}}, round_up});
  assign speed    = qr[7:0];

endmodule

@@ rtl/line_follow_wheel_speed.sv @@
// ============================================================================
// line_follow_wheel_speed
// Turns the line slope and lateral deviation of each camera frame into left
// and right wheel speed commands.
// ============================================================================
//
//  Channel  Direction  Beat contents
//  -------  ---------  -----------------------------------------------------
//  s_*      in         tdata: slope, deviation; tuser: invalid, func
//  m_*      out        tdata: left_speed, right_speed
//  cfg_*    in         one register write per cycle with cfg_we high
//
// A valid frame runs five or six multiplies through one digit-serial
// multiplier that consumes a 4-bit digit per cycle: five in far mode or
// without the growth term, six in near mode with the growth term. An
// invalid frame skips the multiplies and goes straight to the output
// state. The shared multiplier sets the rate: one frame is processed at
// a time and s_tready is high only in idle. The output beat sits in its
// own register, so a new frame is taken while the previous result waits
// for m_tready. Reset is synchronous and active high; it restores the
// register defaults and clears the held speeds and the last deviation.
//
module line_follow_wheel_speed
  import lfws_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] slope, [63:32] deviation
  input  logic [2:0]  s_tuser,   // [0] invalid, [2:1] func

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] left_speed, [15:8] right_speed

  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // Width of the speed sums: the midpoint scaled by the fraction plus a
  // full 32-bit drive term.
  localparam int SW = ((FRAC_BITS + 10) > 34) ? (FRAC_BITS + 10) : 34;
  localparam logic signed [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);
  localparam logic        [30:0] BETA_1 = 31'(64'd1 << FRAC_BITS);

  // Configuration registers.
  logic signed [31:0] dev_weight;
  logic signed [31:0] growth_weight;
  logic signed [31:0] slope_weight;
  logic        [30:0] beta_limit;
  logic signed [31:0] near_gain;
  logic signed [31:0] far_gain;
  logic signed [7:0]  min_speed;
  logic signed [7:0]  max_speed;

  // Frame state kept across frames.
  logic signed [31:0] last_deviation;
  logic signed [7:0]  held_left;
  logic signed [7:0]  held_right;

  // Working registers of the current frame.
  lfws_state_t        state;
  lfws_state_t        state_next;
  logic               go;
  logic               go_next;
  logic signed [31:0] slope_r;
  logic signed [31:0] dev_r;
  logic signed [31:0] diff_r;
  logic [1:0]         func_r;
  logic               near_r;
  logic signed [31:0] extra;
  logic signed [31:0] u;
  logic signed [31:0] p;
  logic signed [SW-1:0] vl;
  logic signed [SW-1:0] vr;
  logic signed [7:0]  left_speed;
  logic signed [7:0]  right_speed;

  // Input beat decode.
  logic signed [31:0] slope_in;
  logic signed [31:0] dev_in;
  logic               invalid_in;
  logic [1:0]         func_in;
  logic signed [31:0] diff_in;
  logic signed [32:0] slope_x;
  logic signed [32:0] beta_x;
  logic               near_in;
  logic               extra_in;
  logic               accept;
  logic               out_load;

  // Multiplier connection.
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_done;
  logic signed [31:0] mul_res;

  // Speed path.
  logic signed [8:0]    mid_sum;
  logic signed [SW-1:0] mid;
  logic signed [SW-1:0] drive_x;
  logic signed [7:0]    conv_left;
  logic signed [7:0]    conv_right;

  assign slope_in   = s_tdata[31:0];
  assign dev_in     = s_tdata[63:32];
  assign invalid_in = s_tuser[0];
  assign func_in    = s_tuser[2:1];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_load = (state == ST_OUT) & (~m_tvalid | m_tready);

  // Near mode holds while the slope lies strictly inside the band.
  assign slope_x = {slope_in[31], slope_in};
  assign beta_x  = {2'b00, beta_limit};
  assign near_in = (slope_x > -beta_x) && (slope_x < beta_x);

  // The growth term applies only while the deviation moves further out.
  assign diff_in  = sat33({dev_in[31], dev_in} - {last_deviation[31], last_deviation});
  assign extra_in = ((~dev_in[31] & (|dev_in)) && (~diff_in[31] & (|diff_in)))
                  || (dev_in[31] && diff_in[31]);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_weight    <= ONE_Q;
      growth_weight <= '0;
      slope_weight  <= ONE_Q;
      beta_limit    <= BETA_1;
      near_gain     <= '0;
      far_gain      <= '0;
      min_speed     <= '0;
      max_speed     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEV_WEIGHT:    dev_weight    <= cfg_wdata;
        REG_GROWTH_WEIGHT: growth_weight <= cfg_wdata;
        REG_SLOPE_WEIGHT:  slope_weight  <= cfg_wdata;
        REG_BETA_LIMIT:    beta_limit    <= cfg_wdata[30:0];
        REG_NEAR_GAIN:     near_gain     <= cfg_wdata;
        REG_FAR_GAIN:      far_gain      <= cfg_wdata;
        REG_MIN_SPEED:     min_speed     <= cfg_wdata[7:0];
        REG_MAX_SPEED:     max_speed     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go    <= 1'b0;
    end else begin
      state <= state_next;
      go    <= go_next;
    end
  end

  // Each multiply state launches the multiplier once on entry and waits
  // for its done pulse.
  always_comb begin
    state_next = state;
    go_next    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (invalid_in) begin
            state_next = ST_OUT;
          end else if (near_in && extra_in) begin
            state_next = ST_EXTRA;
            go_next    = 1'b1;
          end else begin
            state_next = ST_TERM;
            go_next    = 1'b1;
          end
        end
      end
      ST_EXTRA: begin
        if (mul_done) begin
          state_next = ST_TERM;
          go_next    = 1'b1;
        end
      end
      ST_TERM: begin
        if (mul_done) begin
          state_next = ST_P2;
          go_next    = 1'b1;
        end
      end
      ST_P2: begin
        if (mul_done) begin
          state_next = ST_P4;
          go_next    = 1'b1;
        end
      end
      ST_P4: begin
        if (mul_done) begin
          state_next = ST_P5;
          go_next    = 1'b1;
        end
      end
      ST_P5: begin
        if (mul_done) begin
          state_next = ST_DRIVE;
          go_next    = 1'b1;
        end
      end
      ST_DRIVE: begin
        if (mul_done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = p;
    mul_b = u;
    case (state)
      ST_EXTRA: begin
        mul_a = growth_weight;
        mul_b = diff_r;
      end
      ST_TERM: begin
        mul_a = near_r ? dev_weight : slope_weight;
        mul_b = near_r ? dev_r : slope_r;
      end
      ST_P2: begin
        mul_a = u;
        mul_b = u;
      end
      ST_P4: begin
        mul_a = p;
        mul_b = p;
      end
      ST_P5: begin
        mul_a = p;
        mul_b = u;
      end
      ST_DRIVE: begin
        mul_a = near_r ? near_gain : far_gain;
        mul_b = p;
      end
      default: begin
        mul_a = p;
        mul_b = u;
      end
    endcase
  end

  lfws_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Midpoint of the speed range, in the fixed-point scale.
  assign mid_sum = {min_speed[7], min_speed} + {max_speed[7], max_speed};
  assign mid     = $signed({{(SW-9){mid_sum[8]}}, mid_sum}) <<< (FRAC_BITS - 1);
  assign drive_x = $signed({{(SW-32){p[31]}}, p});

  lfws_spd #(
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW)
  ) u_spd_left (
    .v         (vl),
    .min_speed (min_speed),
    .max_speed (max_speed),
    .speed     (conv_left)
  );

  lfws_spd #(
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW)
  ) u_spd_right (
    .v         (vr),
    .min_speed (min_speed),
    .max_speed (max_speed),
    .speed     (conv_right)
  );

  // Frame state: only a valid frame updates it, whatever the function code.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_deviation <= '0;
      held_left      <= '0;
      held_right     <= '0;
    end else begin
      if (state == ST_SUM) begin
        last_deviation <= dev_r;
      end
      if (state == ST_CLAMP) begin
        held_left  <= conv_left;
        held_right <= conv_right;
      end
    end
  end

  // Datapath registers of the current frame.
  always_ff @(posedge clk) begin
    if (accept) begin
      slope_r <= slope_in;
      dev_r   <= dev_in;
      diff_r  <= diff_in;
      func_r  <= func_in;
      near_r  <= near_in;
      extra   <= '0;
    end
    if (mul_done) begin
      case (state)
        ST_EXTRA: extra <= mul_res;
        ST_TERM: begin
          if (near_r) begin
            u <= sat33({extra[31], extra} + {mul_res[31], mul_res});
          end else begin
            u <= sat33(33'sd0 - {mul_res[31], mul_res});
          end
        end
        ST_P2, ST_P4, ST_P5, ST_DRIVE: p <= mul_res;
        default: ;
      endcase
    end
    if (state == ST_SUM) begin
      vl <= mid + drive_x;
      vr <= mid - drive_x;
    end
  end

  // Output register. The held speeds are the result of the last valid
  // frame, which is this frame's result unless it was marked invalid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      case (func_r)
        FUNC_SPRAY_STOP: begin
          left_speed  <= '0;
          right_speed <= '0;
        end
        FUNC_SPRAY_REV: begin
          left_speed  <= REVERSE_SPEED;
          right_speed <= REVERSE_SPEED;
        end
        FUNC_FOLLOW, FUNC_SPRAY_FWD: begin
          left_speed  <= held_left;
          right_speed <= held_right;
        end
        default: begin
          left_speed  <= held_left;
          right_speed <= held_right;
        end
      endcase
    end
  end

  assign m_tdata = {right_speed, left_speed};

endmodule
